// ===== hdl/mfa_pkg.sv =====
// ----------------------------------------------------------------------------
// mfa_pkg: shared types and constants for the mixed fraction ALU
// Request and result formats, operation codes and the divider chain data.
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int RES_BITS      = 48;
  localparam int PA_W          = 2 * OPERAND_WIDTH + 1;
  localparam int PROD_W        = (4 * OPERAND_WIDTH + 2 > RES_BITS) ?
                                 4 * OPERAND_WIDTH + 2 : RES_BITS;
  localparam int FRONT_STAGES  = 4;
  localparam int LATENCY       = FRONT_STAGES + RES_BITS + 1;

  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_NEG = 4'd4;
  localparam logic [3:0] KIND_EQ  = 4'd5;
  localparam logic [3:0] KIND_NE  = 4'd6;
  localparam logic [3:0] KIND_LT  = 4'd7;
  localparam logic [3:0] KIND_GE  = 4'd8;
  localparam logic [3:0] KIND_GT  = 4'd9;
  localparam logic [3:0] KIND_LE  = 4'd10;

  typedef struct packed {
    logic        [3:0]               kind;
    logic signed [OPERAND_WIDTH-1:0] a_whole;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_whole;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
  } req_t;

  typedef struct packed {
    logic signed [RES_BITS-1:0] res_whole;
    logic signed [RES_BITS-1:0] res_num;
    logic signed [RES_BITS-1:0] res_den;
    logic                       compare_true;
    logic                       valid_res;
  } res_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic                       arith;
    logic                       valid;
    logic                       cmp;
    logic                       neg_q;
    logic                       neg_r;
    logic signed [RES_BITS-1:0] whole;
    logic signed [RES_BITS-1:0] num;
    logic signed [RES_BITS-1:0] den;
  } side_t;

  typedef struct packed {
    logic [RES_BITS-1:0] rem;
    logic [RES_BITS-1:0] quo;
    logic [RES_BITS-1:0] dvs;
    side_t               side;
  } stage_t;

endpackage

// ===== hdl/mfa_front.sv =====
// ----------------------------------------------------------------------------
// mfa_front: operand preparation pipeline
// Forms improper numerators, cross products, compare flags and the
// magnitudes that enter the divider chain.
// ----------------------------------------------------------------------------
module mfa_front
  import mfa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_v,
  input  req_t   req,
  output logic   out_v,
  output stage_t out_stage
);

  // stage 1
  logic                            v1;
  logic        [3:0]               kind1;
  logic signed [PA_W-1:0]          pa1, pb1;
  logic signed [OPERAND_WIDTH-1:0] aw1, an1, ad1, bd1;
  // stage 2
  logic                            v2;
  logic        [3:0]               kind2;
  logic signed [PROD_W-1:0]        p1, p2, p3, p4;
  logic signed [OPERAND_WIDTH-1:0] aw2, an2, ad2, bd2;
  // stage 3
  logic                            v3;
  logic signed [RES_BITS-1:0]      n3, d3;
  side_t                           side3;

  logic signed [PA_W-1:0]     pa_c, pb_c;
  logic signed [PROD_W-1:0]   n_full, d_full, x_full;
  logic signed [RES_BITS-1:0] n_c, d_c;
  logic                       lt_c, eq_c, gt_c, flip_c, dens_ok;
  side_t                      side_c;

  assign pa_c = PA_W'(req.a_whole) * PA_W'(req.a_den) + PA_W'(req.a_num);
  assign pb_c = PA_W'(req.b_whole) * PA_W'(req.b_den) + PA_W'(req.b_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
      out_v <= v3;
    end
  end

  always_ff @(posedge clk) begin
    kind1 <= req.kind;
    pa1   <= pa_c;
    pb1   <= pb_c;
    aw1   <= req.a_whole;
    an1   <= req.a_num;
    ad1   <= req.a_den;
    bd1   <= req.b_den;
  end

  always_ff @(posedge clk) begin
    kind2 <= kind1;
    p1    <= PROD_W'(pa1) * PROD_W'(bd1);
    p2    <= PROD_W'(pb1) * PROD_W'(ad1);
    p3    <= PROD_W'(pa1) * PROD_W'(pb1);
    p4    <= PROD_W'(ad1) * PROD_W'(bd1);
    aw2   <= aw1;
    an2   <= an1;
    ad2   <= ad1;
    bd2   <= bd1;
  end

  always_comb begin
    case (kind2)
      KIND_ADD: n_full = p1 + p2;
      KIND_SUB: n_full = p1 - p2;
      KIND_MUL: n_full = p3;
      default:  n_full = p1;
    endcase
    d_full = (kind2 == KIND_DIV) ? p2 : p4;
    n_c    = n_full[RES_BITS-1:0];
    d_c    = d_full[RES_BITS-1:0];

    // sign of the exact difference, flipped when one denominator is negative
    x_full  = p1 - p2;
    flip_c  = ad2[OPERAND_WIDTH-1] ^ bd2[OPERAND_WIDTH-1];
    eq_c    = (x_full == '0);
    lt_c    = !eq_c && (x_full[PROD_W-1] ^ flip_c);
    gt_c    = !eq_c && !lt_c;
    dens_ok = (ad2 != '0) && (bd2 != '0);

    side_c = '0;
    case (kind2)
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
        side_c.arith = 1'b1;
        side_c.valid = dens_ok && (d_c != '0);
        side_c.neg_q = n_c[RES_BITS-1] ^ d_c[RES_BITS-1];
        side_c.neg_r = n_c[RES_BITS-1];
        side_c.den   = d_c;
      end
      KIND_NEG: begin
        if (ad2 != '0) begin
          side_c.valid = 1'b1;
          side_c.den   = RES_BITS'(ad2);
          if (aw2 == '0) begin
            side_c.num = -RES_BITS'(an2);
          end else begin
            side_c.whole = -RES_BITS'(aw2);
            side_c.num   = RES_BITS'(an2);
          end
        end
      end
      KIND_EQ, KIND_NE, KIND_LT, KIND_GE, KIND_GT, KIND_LE: begin
        side_c.valid = dens_ok;
        case (kind2)
          KIND_EQ: side_c.cmp = dens_ok && eq_c;
          KIND_NE: side_c.cmp = dens_ok && !eq_c;
          KIND_LT: side_c.cmp = dens_ok && lt_c;
          KIND_GE: side_c.cmp = dens_ok && !lt_c;
          KIND_GT: side_c.cmp = dens_ok && gt_c;
          default: side_c.cmp = dens_ok && !gt_c;
        endcase
      end
      default: side_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    n3    <= n_c;
    d3    <= d_c;
    side3 <= side_c;
  end

  // take magnitudes; the most negative value maps to 2^47 unsigned
  always_ff @(posedge clk) begin
    out_stage.rem  <= '0;
    out_stage.quo  <= n3[RES_BITS-1] ? -n3 : n3;
    out_stage.dvs  <= d3[RES_BITS-1] ? -d3 : d3;
    out_stage.side <= side3;
  end

endmodule

// ===== hdl/mfa_div_cell.sv =====
// ----------------------------------------------------------------------------
// mfa_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
module mfa_div_cell
  import mfa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_v,
  input  stage_t in_stage,
  output logic   out_v,
  output stage_t out_stage
);

  logic [RES_BITS-1:0] shifted;
  logic [RES_BITS:0]   diff;
  logic                fits;

  assign shifted = {in_stage.rem[RES_BITS-2:0], in_stage.quo[RES_BITS-1]};
  assign diff    = {1'b0, shifted} - {1'b0, in_stage.dvs};
  assign fits    = !diff[RES_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    out_stage.rem  <= fits ? diff[RES_BITS-1:0] : shifted;
    out_stage.quo  <= {in_stage.quo[RES_BITS-2:0], fits};
    out_stage.dvs  <= in_stage.dvs;
    out_stage.side <= in_stage.side;
  end

endmodule

// ===== hdl/mixed_fraction_alu_unit.sv =====
// ----------------------------------------------------------------------------
// mixed_fraction_alu_unit: mixed fraction arithmetic and compare unit
// Add, subtract, multiply, divide, negate and six comparisons on mixed
// fractions, with a bit-per-cell pipelined signed divider.
// ----------------------------------------------------------------------------
// Pipeline from accepted request to the done strobe: 4 preparation stages,
// one divider cell per result bit (48 cells), and one output register.
// Throughput: one request per cycle; busy stays low, and results cannot stall.
// Reset: synchronous rst clears every stage valid bit; requests in flight drop.
module mixed_fraction_alu_unit
  import mfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t res
);

  logic   v_chain [RES_BITS+1];
  stage_t s_chain [RES_BITS+1];
  stage_t last;
  logic [RES_BITS-1:0] q_mag, r_mag;

  assign busy = 1'b0;

  mfa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_v     (start && !busy),
    .req      (req),
    .out_v    (v_chain[0]),
    .out_stage(s_chain[0])
  );

  for (genvar i = 0; i < RES_BITS; i++) begin : g_cell
    mfa_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_v     (v_chain[i]),
      .in_stage (s_chain[i]),
      .out_v    (v_chain[i+1]),
      .out_stage(s_chain[i+1])
    );
  end

  assign last  = s_chain[RES_BITS];
  assign q_mag = last.quo;
  assign r_mag = last.rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_chain[RES_BITS];
    end
  end

  always_ff @(posedge clk) begin
    res.compare_true <= last.side.cmp;
    res.valid_res    <= last.side.valid;
    res.res_den      <= last.side.valid ? last.side.den : '0;
    if (!last.side.valid) begin
      res.res_whole <= '0;
      res.res_num   <= '0;
    end else if (last.side.arith) begin
      res.res_whole <= last.side.neg_q ? -q_mag : q_mag;
      res.res_num   <= last.side.neg_r ? -r_mag : r_mag;
    end else begin
      res.res_whole <= last.side.whole;
      res.res_num   <= last.side.num;
    end
  end

endmodule

// ===== hdl/mfa_checker.sv =====
// ----------------------------------------------------------------------------
// mfa_checker: port-level checks for the mixed fraction ALU
// Watches request and result timing and result field consistency.
// ----------------------------------------------------------------------------
module mfa_checker
  import mfa_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input res_t res
);

  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request produced no result at the expected cycle");

  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !res.valid_res) |->
      (res.res_whole == '0 && res.res_num == '0 && res.res_den == '0 &&
       !res.compare_true))
    else $error("invalid result carries nonzero fields");

  a_compare_clean: assert property (@(posedge clk) disable iff (rst)
    (done && res.compare_true) |->
      (res.valid_res && res.res_den == '0 && res.res_whole == '0))
    else $error("compare flag set on an invalid or arithmetic result");

endmodule

bind mixed_fraction_alu_unit mfa_checker u_mfa_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .res  (res)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: mixed fraction ALU unit testbench
// Sends fraction requests through the command handshake in random bursts and
// checks every result strobe against an in-bench arithmetic predictor.
// ----------------------------------------------------------------------------
module tb;
  import mfa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  res_t res;

  res_t expected_q[$];
  int   mismatches = 0;
  bit   gaps_on = 1'b1;

  mixed_fraction_alu_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .res(res)
  );

  always #10 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [47:0] wrap48(logic signed [127:0] v);
    return v[47:0];
  endfunction

  // truncating division on 48-bit values, quotient wraps on overflow
  function automatic void split_frac(logic signed [47:0] n, logic signed [47:0] d,
                                     output logic signed [47:0] w,
                                     output logic signed [47:0] r);
    logic signed [63:0] n64;
    logic signed [63:0] d64;
    logic signed [63:0] q64;
    n64 = 64'(n);
    d64 = 64'(d);
    q64 = n64 / d64;
    w = q64[47:0];
    r = wrap48(128'(n64 - q64 * d64));
  endfunction

  function automatic res_t predict_fraction(req_t q);
    res_t o;
    logic signed [127:0] aw, an, ad, bw, bn, bd, pa, pb, l, r;
    logic signed [47:0] n, d;
    int c;
    o = '0;
    aw = 128'(q.a_whole); an = 128'(q.a_num); ad = 128'(q.a_den);
    bw = 128'(q.b_whole); bn = 128'(q.b_num); bd = 128'(q.b_den);
    pa = aw * ad + an;
    pb = bw * bd + bn;
    if (q.kind <= KIND_DIV) begin
      if (ad != 0 && bd != 0) begin
        case (q.kind)
          KIND_ADD: begin n = wrap48(pa * bd + pb * ad); d = wrap48(ad * bd); end
          KIND_SUB: begin n = wrap48(pa * bd - pb * ad); d = wrap48(ad * bd); end
          KIND_MUL: begin n = wrap48(pa * pb); d = wrap48(ad * bd); end
          default:  begin n = wrap48(pa * bd); d = wrap48(ad * pb); end
        endcase
        if (d != 0) begin
          split_frac(n, d, o.res_whole, o.res_num);
          o.res_den = d;
          o.valid_res = 1'b1;
        end
      end
    end else if (q.kind == KIND_NEG) begin
      if (ad != 0) begin
        if (aw == 0) o.res_num = wrap48(-an);
        else begin
          o.res_whole = wrap48(-aw);
          o.res_num = wrap48(an);
        end
        o.res_den = wrap48(ad);
        o.valid_res = 1'b1;
      end
    end else if (q.kind <= KIND_LE) begin
      if (ad != 0 && bd != 0) begin
        if (ad < 0) begin pa = -pa; ad = -ad; end
        if (bd < 0) begin pb = -pb; bd = -bd; end
        l = pa * bd;
        r = pb * ad;
        c = (l < r) ? -1 : ((l > r) ? 1 : 0);
        case (q.kind)
          KIND_EQ: o.compare_true = (c == 0);
          KIND_NE: o.compare_true = (c != 0);
          KIND_LT: o.compare_true = (c < 0);
          KIND_GE: o.compare_true = (c >= 0);
          KIND_GT: o.compare_true = (c > 0);
          default: o.compare_true = (c <= 0);
        endcase
        o.valid_res = 1'b1;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", '0, '0);
      else begin
        want = expected_q.pop_front();
        if (res.res_whole !== want.res_whole)
          report_mismatch("res_whole", res.res_whole, want.res_whole);
        if (res.res_num !== want.res_num)
          report_mismatch("res_num", res.res_num, want.res_num);
        if (res.res_den !== want.res_den)
          report_mismatch("res_den", res.res_den, want.res_den);
        if (res.compare_true !== want.compare_true)
          report_mismatch("compare_true", 48'(res.compare_true),
                          48'(want.compare_true));
        if (res.valid_res !== want.valid_res)
          report_mismatch("valid_res", 48'(res.valid_res), 48'(want.valid_res));
      end
    end
  end

  int burst_left = 0;

  // hold start across back-to-back requests; drop it only for a gap
  task automatic send_request(req_t q);
    if (gaps_on) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    start <= 1'b1;
    req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_fraction(q));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return $urandom_range(0, 1) ? 16'hffff : 16'h0001;
      4, 5: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  function automatic logic [15:0] pick_den();
    logic [15:0] v;
    v = pick_operand();
    if (v == 0 && $urandom_range(0, 7) != 0) v = 16'd3;
    return v;
  endfunction

  function automatic req_t random_request();
    req_t q;
    q.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
    q.a_whole = pick_operand();
    q.a_num = pick_operand();
    q.a_den = pick_den();
    q.b_whole = pick_operand();
    q.b_num = pick_operand();
    q.b_den = pick_den();
    return q;
  endfunction

  task automatic wait_drain();
    go_idle();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    req_t q;
    logic [3:0] k;
    // every kind, including unused ones, on a plain pair
    for (int i = 0; i < 16; i++) begin
      k = 4'(i);
      q = '{k, 16'sd1, 16'sd1, 16'sd2, -16'sd2, 16'sd3, 16'sd4};
      send_request(q);
    end
    send_request('{KIND_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_request('{KIND_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000});
    send_request('{KIND_DIV, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd5});
    send_request('{KIND_SUB, 16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1});
    send_request('{KIND_NEG, 16'sd0, 16'sd5, 16'sd7, 16'sd0, 16'sd0, 16'sd0});
    send_request('{KIND_NEG, -16'sd3, 16'sd5, -16'sd7, 16'sd0, 16'sd0, 16'sd0});
    send_request('{KIND_EQ, 16'sd1, 16'sd1, 16'sd2, 16'sd1, -16'sd2, -16'sd4});
    // divide with the second denominator at the most negative value
    send_request('{KIND_DIV, 16'sd0, 16'sh8000, 16'sd1, 16'sh4000, 16'sd0, 16'sh8000});
    send_request('{KIND_LT, 16'sh7fff, 16'sd0, 16'sh8000, 16'sh8000, 16'sd0, 16'sh8000});
  endtask

  task automatic test_random_burst();
    for (int i = 0; i < 1800; i++) begin
      send_request(random_request());
      if (i == 600) begin
        wait_drain();
        gaps_on = 1'b0;
      end
      if (i == 1000) gaps_on = 1'b1;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_random_burst();
    wait_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
